/* src/slrd_pkg.sv */
// ----------------------------------------------------------------------------
// slrd_pkg: shared types and constants of the scan line record decoder
// Item layouts, the command passed from front to back, and the shade table.
// ----------------------------------------------------------------------------
package slrd_pkg;

  localparam int LINE_WIDTH_DEF = 4096;
  localparam int Q_DEPTH        = 4;

  localparam logic [7:0]  SHADE_OVER  = 8'd253;
  localparam logic [7:0]  SHADE_UNDER = 8'd254;
  localparam logic [3:0]  NPIX_GRAY   = 4'd4;
  localparam logic [3:0]  NPIX_BW     = 4'd12;
  localparam logic [12:0] NZ_MAX      = 13'h1FFF;
  localparam logic [15:0] OVF_MAX     = 16'hFFFF;

  typedef struct packed {
    logic        kind;
    logic        is_image;
    logic        is_raw;
    logic        is_eol;
    logic        is_gray;
    logic [11:0] pix_bits;
  } slrd_in_t;

  typedef struct packed {
    logic [11:0] column;
    logic [12:0] run_length;
    logic [7:0]  shade;
    logic        line_end;
    logic [12:0] pixels_in_line;
    logic        last;
  } slrd_out_t;

  typedef enum logic [1:0] {
    OP_GRAY,
    OP_BW,
    OP_BLANK,
    OP_END
  } slrd_op_t;

  typedef struct packed {
    slrd_op_t    op;
    logic        eol;
    logic [11:0] bits;
  } slrd_cmd_t;

  function automatic logic [7:0] shade_of(input logic [2:0] level);
    logic [7:0] s;
    case (level)
      3'd0:    s = 8'd0;
      3'd1:    s = 8'd36;
      3'd2:    s = 8'd73;
      3'd3:    s = 8'd109;
      3'd4:    s = 8'd146;
      3'd5:    s = 8'd182;
      3'd6:    s = 8'd219;
      default: s = 8'd255;
    endcase
    return s;
  endfunction

endpackage

/* src/slrd_front.sv */
// ----------------------------------------------------------------------------
// slrd_front: record classifier
// Sorts incoming records into commands and drops records without image data.
// ----------------------------------------------------------------------------
module slrd_front
  import slrd_pkg::*;
(
  input  logic      in_push,
  input  slrd_in_t  in_data,
  input  logic      q_full,
  output logic      q_push,
  output slrd_cmd_t q_cmd
);

  logic keep;

  // non-image camera records cause nothing, so they never reach the queue
  assign keep   = in_data.kind || in_data.is_image;
  assign q_push = in_push && !q_full && keep;

  always_comb begin
    q_cmd.eol  = in_data.is_eol;
    q_cmd.bits = in_data.pix_bits;
    if (in_data.kind) begin
      q_cmd.op = OP_END;
    end else if (!in_data.is_raw) begin
      q_cmd.op = OP_BLANK;
    end else if (in_data.is_gray) begin
      q_cmd.op = OP_GRAY;
    end else begin
      q_cmd.op = OP_BW;
    end
  end

endmodule

/* src/slrd_fifo.sv */
// ----------------------------------------------------------------------------
// slrd_fifo: command queue
// Short queue between classifier and line builder, head read directly.
// ----------------------------------------------------------------------------
module slrd_fifo
  import slrd_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push,
  input  slrd_cmd_t push_cmd,
  input  logic      pop,
  output slrd_cmd_t head,
  output logic      full,
  output logic      empty
);

  localparam int PTR_W = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
  localparam int CNT_W = $clog2(Q_DEPTH + 1);

  slrd_cmd_t            slot_r [Q_DEPTH];
  logic [PTR_W-1:0]     wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]     rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]     cnt_r, cnt_nxt;
  logic                 do_push, do_pop;

  assign full    = (cnt_r == CNT_W'(Q_DEPTH));
  assign empty   = (cnt_r == '0);
  assign head    = slot_r[rd_ptr_r];
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

/* src/slrd_back.sv */
// ----------------------------------------------------------------------------
// slrd_back: line builder
// Steps through one command per queue head, one run per cycle while the output is free, and keeps
// the line state (column, overflow, nonzero count).
// ----------------------------------------------------------------------------
module slrd_back
  import slrd_pkg::*;
#(
  parameter int LINE_WIDTH = LINE_WIDTH_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  slrd_cmd_t cmd,
  input  logic      q_empty,
  output logic      q_pop,
  output logic      out_empty,
  input  logic      out_pop,
  output slrd_out_t out_data
);

  localparam int COL_W = $clog2(LINE_WIDTH + 1);
  localparam int SUM_W = (COL_W > 14) ? COL_W : 14;
  localparam logic [COL_W-1:0] WIDTH_C = COL_W'(LINE_WIDTH);
  localparam logic [15:0]      WIDTH_16 = 16'(LINE_WIDTH);

  typedef enum logic [1:0] {
    S_BODY,
    S_CLOSE,
    S_OVER
  } state_t;

  state_t           st_r, st_nxt;
  logic [3:0]       idx_r, idx_nxt;
  logic [COL_W-1:0] col_r, col_nxt;
  logic [15:0]      ovf_r, ovf_nxt;
  logic [12:0]      nz_r, nz_nxt;
  slrd_out_t        out_r, out_nxt;
  logic             out_valid_r, out_valid_nxt;

  logic             step;
  logic             emit;
  slrd_out_t        res;
  logic [3:0]       npix;
  logic [2:0]       level;
  logic [COL_W-1:0] col_inc;
  logic [SUM_W-1:0] run_len, space, fit;
  logic [15:0]      over_len;

  function automatic logic [15:0] sat_add(input logic [15:0] a, input logic [15:0] b);
    logic [16:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[16] ? OVF_MAX : s[15:0];
  endfunction

  assign out_empty = !out_valid_r;
  assign out_data  = out_r;
  assign step      = !q_empty && (!out_valid_r || out_pop);
  assign npix      = (cmd.op == OP_GRAY) ? NPIX_GRAY : NPIX_BW;
  assign col_inc   = col_r + 1'b1;
  assign run_len   = SUM_W'({cmd.bits, 2'b00});
  assign space     = SUM_W'(WIDTH_C - col_r);
  assign fit       = (run_len < space) ? run_len : space;
  assign over_len  = (ovf_r < WIDTH_16) ? ovf_r : WIDTH_16;

  // gray groups come wire-swapped: 8..6, 11..9, 2..0, 5..3
  always_comb begin
    if (cmd.op == OP_GRAY) begin
      case (idx_r[1:0])
        2'd0:    level = cmd.bits[8:6];
        2'd1:    level = cmd.bits[11:9];
        2'd2:    level = cmd.bits[2:0];
        default: level = cmd.bits[5:3];
      endcase
    end else begin
      level = cmd.bits[4'd11 - idx_r] ? 3'd7 : 3'd0;
    end
  end

  always_comb begin
    st_nxt        = st_r;
    idx_nxt       = idx_r;
    col_nxt       = col_r;
    ovf_nxt       = ovf_r;
    nz_nxt        = nz_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r && !out_pop;
    q_pop         = 1'b0;
    emit          = 1'b0;
    res           = '0;

    if (step) begin
      case (st_r)
        S_BODY: begin
          case (cmd.op)
            OP_END: begin
              if (col_r == '0) begin
                q_pop = 1'b1;
              end else begin
                st_nxt = S_CLOSE;
              end
            end
            OP_BLANK: begin
              ovf_nxt = sat_add(ovf_r, 16'(run_len - fit));
              if (fit != '0) begin
                emit           = 1'b1;
                res.column     = 12'(col_r);
                res.run_length = 13'(fit);
                res.last       = !cmd.eol;
              end
              col_nxt = col_r + COL_W'(fit);
              if (cmd.eol) begin
                st_nxt = S_CLOSE;
              end else begin
                q_pop = 1'b1;
              end
            end
            default: begin
              if (col_r < WIDTH_C) begin
                emit           = 1'b1;
                res.column     = 12'(col_r);
                res.run_length = 13'd1;
                res.shade      = shade_of(level);
                // later pixels of this item fall past the line end
                res.last       = !cmd.eol && ((idx_r == npix - 1'b1) || (col_inc == WIDTH_C));
                col_nxt        = col_inc;
                if (level != 3'd0 && nz_r != NZ_MAX) begin
                  nz_nxt = nz_r + 1'b1;
                end
              end else begin
                ovf_nxt = sat_add(ovf_r, 16'(npix - idx_r));
              end
              if ((col_r < WIDTH_C) && (idx_r != npix - 1'b1)) begin
                idx_nxt = idx_r + 1'b1;
              end else begin
                idx_nxt = '0;
                if (cmd.eol) begin
                  st_nxt = S_CLOSE;
                end else begin
                  q_pop = 1'b1;
                end
              end
            end
          endcase
        end
        S_CLOSE: begin
          emit               = 1'b1;
          res.column         = 12'(col_r);
          res.line_end       = 1'b1;
          res.pixels_in_line = nz_r;
          res.last           = (ovf_r == '0);
          if (col_r < WIDTH_C) begin
            res.run_length = 13'(WIDTH_C - col_r);
            res.shade      = SHADE_UNDER;
          end
          col_nxt = '0;
          nz_nxt  = '0;
          if (ovf_r != '0) begin
            st_nxt = S_OVER;
          end else begin
            st_nxt = S_BODY;
            q_pop  = 1'b1;
          end
        end
        S_OVER: begin
          emit           = 1'b1;
          res.run_length = 13'(over_len);
          res.shade      = SHADE_OVER;
          res.line_end   = 1'b1;
          res.last       = 1'b1;
          ovf_nxt        = '0;
          st_nxt         = S_BODY;
          q_pop          = 1'b1;
        end
        default: begin
          st_nxt = S_BODY;
        end
      endcase
    end

    if (emit) begin
      out_nxt       = res;
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= S_BODY;
      idx_r       <= '0;
      col_r       <= '0;
      ovf_r       <= '0;
      nz_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      st_r        <= st_nxt;
      idx_r       <= idx_nxt;
      col_r       <= col_nxt;
      ovf_r       <= ovf_nxt;
      nz_r        <= nz_nxt;
      out_valid_r <= out_valid_nxt;
    end
    out_r <= out_nxt;
  end

endmodule

/* src/scan_line_record_decoder.sv */
// ----------------------------------------------------------------------------
// scan_line_record_decoder: scan line rebuilder for line-scan camera records
// Turns camera records into pixel runs of fixed-width scan lines.
// ----------------------------------------------------------------------------
// Usage
//   in_*  : records are pushed while in_full is low; records without image
//           data are taken and dropped at once.
//   out_* : runs wait on out_data while out_empty is low; out_pop takes one.
//   Each record yields 0 to 14 runs; last marks the final run of a record.
// Path: a record is written into the command queue, and its first run is then
//   registered in the output register.
// Throughput: one run per cycle from the single line builder while out_pop
//   keeps the output free; each run takes a builder step (up to 14 for a raw
//   black-and-white record closing a line with overflow), and a body that
//   emits nothing takes a step too: an end-of-data record, a blank run that
//   does not fit, or raw pixels that spill past the line end. A 4-deep
//   command queue lets records arrive while earlier ones are being expanded.
// Reset: clears the queue, the output valid flag and the line state (column,
//   overflow and nonzero counts, builder state and pixel index).
// Stall: while a run waits unpopped the builder holds; once the queue fills
//   in_full rises and stays high until space frees up.
// ----------------------------------------------------------------------------
module scan_line_record_decoder
  import slrd_pkg::*;
#(
  parameter int LINE_WIDTH = LINE_WIDTH_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_push,
  output logic      in_full,
  input  slrd_in_t  in_data,
  output logic      out_empty,
  input  logic      out_pop,
  output slrd_out_t out_data
);

  logic      q_push, q_pop, q_full, q_empty;
  slrd_cmd_t q_cmd, q_head;

  assign in_full = q_full;

  slrd_front u_front (
    .in_push (in_push),
    .in_data (in_data),
    .q_full  (q_full),
    .q_push  (q_push),
    .q_cmd   (q_cmd)
  );

  slrd_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_cmd (q_cmd),
    .pop      (q_pop),
    .head     (q_head),
    .full     (q_full),
    .empty    (q_empty)
  );

  slrd_back #(
    .LINE_WIDTH (LINE_WIDTH)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (q_head),
    .q_empty   (q_empty),
    .q_pop     (q_pop),
    .out_empty (out_empty),
    .out_pop   (out_pop),
    .out_data  (out_data)
  );

  // nothing waits on the result side right after reset
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> out_empty)
    else $error("result pending after reset");

  // overflow line always starts at column 0, closes a line and ends its item
  a_over_line: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && out_data.shade == SHADE_OVER) |->
      (out_data.column == '0 && out_data.line_end && out_data.last))
    else $error("malformed overflow line");

  // pixel count only travels on a line close
  a_count_on_close: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && !out_data.line_end) |-> (out_data.pixels_in_line == '0))
    else $error("pixel count outside line close");

  // fill runs only appear as line closes
  a_fill_closes: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && out_data.shade == SHADE_UNDER) |-> out_data.line_end)
    else $error("fill run without line close");

endmodule
